@@ rtl/core/tdf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tdf_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int PRIME_BITS     = 32;

    typedef struct packed {
        logic done;
        logic exact;
    } div_status_t;

endpackage

`default_nettype wire

@@ rtl/core/trial_division_factorizer.sv @@
// Each trial runs one division on a bit-serial divider (one quotient bit per
//   cycle); each item also passes through an accept step and a final step.
// Throughput: one item at a time; a 32-bit prime near 2^32 takes about 21850
//   divisions. Small inputs (0, 1) skip the divider and go straight to the final step.
// Reset: rst_n asynchronous, active low; clears the sequencer, the divider and
//   the output register, and the block then accepts a new item.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_factorizer
    import tdf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // value
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic      [PRIME_BITS-1:0]                m_axis_tdata,  // prime
    output logic                                      m_axis_tuser,  // has_factor
    output logic                                      m_axis_tlast
);

    localparam int CAND_BITS = (VALUE_BITS + 1) / 2 + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_EVAL,
        ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        PH_TWO,
        PH_THREE,
        PH_LOW,
        PH_HIGH
    } phase_t;

    state_t                state_reg,      state_next;
    phase_t                phase_reg,      phase_next;
    logic [VALUE_BITS-1:0] rem_reg,        rem_next;
    logic [CAND_BITS-1:0]  cand_reg,       cand_next;
    logic                  check_reg,      check_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [VALUE_BITS-1:0] pend_prime_reg, pend_prime_next;
    logic                  out_valid_reg,  out_valid_next;
    logic [PRIME_BITS-1:0] out_prime_reg,  out_prime_next;
    logic                  out_has_reg,    out_has_next;
    logic                  out_last_reg,   out_last_next;

    logic [VALUE_BITS-1:0] in_value;
    logic [VALUE_BITS-1:0] div_quo;
    div_status_t           div_status;
    logic                  div_start;
    logic                  out_free;
    logic                  past_limit;

    assign in_value   = s_axis_tdata[VALUE_BITS-1:0];
    assign div_start  = (state_reg == ST_START);
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign past_limit = check_reg && (VALUE_BITS'(cand_reg) > div_quo);

    tdf_div #(
        .VALUE_BITS (VALUE_BITS),
        .CAND_BITS  (CAND_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rem_reg),
        .divisor  (cand_reg),
        .quotient (div_quo),
        .status   (div_status)
    );

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        rem_next        = rem_reg;
        cand_next       = cand_reg;
        check_next      = check_reg;
        pend_valid_next = pend_valid_reg;
        pend_prime_next = pend_prime_reg;
        out_valid_next  = out_valid_reg;
        out_prime_next  = out_prime_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    pend_valid_next = 1'b0;
                    if (in_value > VALUE_BITS'(1))
                    begin
                        rem_next   = in_value;
                        cand_next  = CAND_BITS'(2);
                        phase_next = PH_TWO;
                        check_next = 1'b0;
                        state_next = ST_START;
                    end
                    else
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    if (past_limit)
                    begin
                        // leftover cofactor is prime
                        if (rem_reg > VALUE_BITS'(1))
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_prime_next = PRIME_BITS'(pend_prime_reg);
                                out_has_next   = 1'b1;
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_prime_next = rem_reg;
                        end
                        state_next = ST_FINAL;
                    end
                    else if (div_status.exact)
                    begin
                        // hold the new factor back until the next one shows whether it ends the run
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_prime_next = PRIME_BITS'(pend_prime_reg);
                            out_has_next   = 1'b1;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_prime_next = VALUE_BITS'(cand_reg);
                        rem_next        = div_quo;
                        check_next      = 1'b0;
                        state_next      = (div_quo == VALUE_BITS'(1)) ? ST_FINAL : ST_START;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_TWO:
                            begin
                                cand_next  = CAND_BITS'(3);
                                phase_next = PH_THREE;
                                check_next = 1'b0;
                            end
                            PH_THREE:
                            begin
                                cand_next  = CAND_BITS'(5);
                                phase_next = PH_LOW;
                                check_next = 1'b1;
                            end
                            PH_LOW:
                            begin
                                cand_next  = cand_reg + CAND_BITS'(2);
                                phase_next = PH_HIGH;
                                check_next = 1'b0;
                            end
                            PH_HIGH:
                            begin
                                cand_next  = cand_reg + CAND_BITS'(4);
                                phase_next = PH_LOW;
                                check_next = 1'b1;
                            end
                            default:
                            begin
                                phase_next = PH_TWO;
                            end
                        endcase
                        state_next = ST_START;
                    end
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_prime_next  = pend_valid_reg ? PRIME_BITS'(pend_prime_reg) : '0;
                    out_has_next    = pend_valid_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_TWO;
            rem_reg        <= '0;
            cand_reg       <= '0;
            check_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_prime_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_prime_reg  <= '0;
            out_has_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            rem_reg        <= rem_next;
            cand_reg       <= cand_next;
            check_reg      <= check_next;
            pend_valid_reg <= pend_valid_next;
            pend_prime_reg <= pend_prime_next;
            out_valid_reg  <= out_valid_next;
            out_prime_reg  <= out_prime_next;
            out_has_reg    <= out_has_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_prime_reg;
    assign m_axis_tuser  = out_has_reg;
    assign m_axis_tlast  = out_last_reg;

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("factor left pending at end of run");

    a_cand_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !cand_reg[CAND_BITS-1])
        else $error("trial divisor outgrew its range");

    a_rem_above_one: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_START |-> rem_reg > VALUE_BITS'(1))
        else $error("division started on a finished cofactor");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg != ST_IDLE)
        else $error("accepted item not started");

    a_last_has_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINAL && out_free |=> out_valid_reg && out_last_reg)
        else $error("run ended without a last item");

endmodule

`default_nettype wire

@@ rtl/core/tdf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tdf_div
    import tdf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int CAND_BITS  = (VALUE_BITS + 1) / 2 + 2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [CAND_BITS-1:0]  divisor,
    output logic      [VALUE_BITS-1:0] quotient,
    output div_status_t                status
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] quo_reg,  quo_next;
    logic [CAND_BITS-1:0]  part_reg, part_next;
    logic [CAND_BITS-1:0]  dsr_reg,  dsr_next;
    logic [CNT_BITS-1:0]   cnt_reg,  cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [CAND_BITS:0]    trial;
    logic [CAND_BITS:0]    diff;
    logic                  qbit;

    // one quotient bit per cycle: shift the next dividend bit into the partial remainder
    assign trial = {part_reg, quo_reg[VALUE_BITS-1]};
    assign qbit  = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        part_next = part_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            part_next = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_BITS'(VALUE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[VALUE_BITS-2:0], qbit};
            part_next = qbit ? diff[CAND_BITS-1:0] : trial[CAND_BITS-1:0];
            cnt_next  = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            part_reg <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            part_reg <= part_next;
            dsr_reg  <= dsr_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient     = quo_reg;
    assign status.done  = done_reg;
    assign status.exact = (part_reg == '0);

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("division started while busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a finished division");

    a_count_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("bit counter ran out while busy");

endmodule

`default_nettype wire
